// File: hdl/cfc_pkg.sv
// shared types and constants of the command frame checker
package cfc_pkg;

	// frame header byte, both directions
	localparam logic [7:0] FRAME_HEADER = 8'd128;

	// length bytes of the response frames
	localparam logic [7:0] ERR_LENGTH  = 8'd1;
	localparam logic [7:0] CONF_LENGTH = 8'd2;

	// depth of the verdict queue between parser and emitter
	localparam int VQ_DEPTH = 4;

	// width used for byte position compares (covers index up to 2 + 255)
	localparam int CMP_W = 10;

	// configuration register indexes
	localparam logic [1:0] CFG_SET_FUNC  = 2'd0;
	localparam logic [1:0] CFG_ERR_FUNC  = 2'd1;
	localparam logic [1:0] CFG_CONF_FUNC = 2'd2;

	// byte positions of a response frame
	localparam logic [2:0] BYTE_HDR  = 3'd0;
	localparam logic [2:0] BYTE_LEN  = 3'd1;
	localparam logic [2:0] BYTE_FUNC = 3'd2;
	localparam logic [2:0] BYTE_CMD  = 3'd3;
	localparam logic [2:0] BYTE_SUM  = 3'd4;

	// received byte transaction
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       packet_start;
		logic       packet_end;
	} rx_t;

	// response byte transaction
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
		logic [2:0] decoded_command;
	} tx_t;

	// configuration register contents
	typedef struct packed {
		logic [7:0] set_func;
		logic [7:0] err_func;
		logic [7:0] conf_func;
	} cfg_t;

	// packet verdict handed from parser to emitter
	typedef struct packed {
		logic       ok;
		logic [7:0] cmd;
	} verdict_t;

	// verdict queue handshake and status
	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} vq_status_t;

endpackage

// File: hdl/cfc_parser.sv
// front end: parses received bytes and produces one verdict per packet
module cfc_parser #(
	parameter int MAX_PACKET = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cfc_pkg::rx_t      rx,
	input  logic [7:0]        set_func,
	output logic              verdict_valid,
	output cfc_pkg::verdict_t verdict
);

	localparam int CW = $clog2(MAX_PACKET + 2);
	localparam logic [CW-1:0] CNT_SAT = CW'(MAX_PACKET + 1);
	localparam int CMP_W_L = cfc_pkg::CMP_W;

	logic          in_pkt_q;
	logic [CW-1:0] count_q;
	logic [7:0]    len_q, sum_q, func_q, cmd_q;
	logic          hdr_ok_q, sum_seen_q, sum_match_q;

	logic          active;
	logic [CW-1:0] cur_count, nxt_count;
	logic [7:0]    cur_len, cur_sum, cur_func, cur_cmd;
	logic          cur_hdr, cur_seen, cur_match;
	logic [7:0]    nxt_len, nxt_sum, nxt_func, nxt_cmd;
	logic          nxt_hdr, nxt_seen, nxt_match;
	logic [CMP_W_L-1:0] idx_w, end_w;

	assign active = accept && (rx.packet_start || in_pkt_q);

	// packet state as seen by this byte (a start byte begins clean)
	always_comb begin
		cur_count = rx.packet_start ? '0 : count_q;
		cur_len   = rx.packet_start ? '0 : len_q;
		cur_sum   = rx.packet_start ? '0 : sum_q;
		cur_func  = rx.packet_start ? '0 : func_q;
		cur_cmd   = rx.packet_start ? '0 : cmd_q;
		cur_hdr   = rx.packet_start ? 1'b0 : hdr_ok_q;
		cur_seen  = rx.packet_start ? 1'b0 : sum_seen_q;
		cur_match = rx.packet_start ? 1'b0 : sum_match_q;
	end

	assign idx_w = CMP_W_L'(cur_count);
	assign end_w = CMP_W_L'(cur_len) + CMP_W_L'(2);

	// field capture by byte position
	always_comb begin
		nxt_len   = cur_len;
		nxt_sum   = cur_sum;
		nxt_func  = cur_func;
		nxt_cmd   = cur_cmd;
		nxt_hdr   = cur_hdr;
		nxt_seen  = cur_seen;
		nxt_match = cur_match;
		if (idx_w == CMP_W_L'(0)) begin
			nxt_hdr = (rx.rx_byte == cfc_pkg::FRAME_HEADER);
		end else if (idx_w == CMP_W_L'(1)) begin
			nxt_len = rx.rx_byte;
		end else if (idx_w < end_w) begin
			nxt_sum = cur_sum + rx.rx_byte;
			if (idx_w == CMP_W_L'(2)) nxt_func = rx.rx_byte;
			if (idx_w == CMP_W_L'(3)) nxt_cmd = rx.rx_byte;
		end else if (idx_w == end_w) begin
			nxt_seen  = 1'b1;
			nxt_match = (rx.rx_byte == cur_sum);
		end
		nxt_count = (cur_count == CNT_SAT) ? cur_count : cur_count + CW'(1);
	end

	// verdict on the last byte of a packet
	assign verdict_valid = active && rx.packet_end;
	assign verdict       = '{
		ok:  nxt_hdr && nxt_seen && nxt_match && (nxt_len >= 8'd2) &&
			(nxt_func == set_func) && (nxt_count != CNT_SAT),
		cmd: nxt_cmd
	};

	// packet tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q <= 1'b0;
			count_q  <= '0;
		end else if (active) begin
			in_pkt_q <= !rx.packet_end;
			count_q  <= nxt_count;
		end
	end

	// captured packet fields
	always_ff @(posedge clk) begin
		if (active) begin
			len_q       <= nxt_len;
			sum_q       <= nxt_sum;
			func_q      <= nxt_func;
			cmd_q       <= nxt_cmd;
			hdr_ok_q    <= nxt_hdr;
			sum_seen_q  <= nxt_seen;
			sum_match_q <= nxt_match;
		end
	end

endmodule

// File: hdl/cfc_vqueue.sv
// short verdict queue between parser and emitter
module cfc_vqueue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  cfc_pkg::verdict_t wr_data,
	input  logic              rd_en,
	output cfc_pkg::verdict_t rd_data,
	output logic              full,
	output logic              empty
);

	localparam int DEPTH = cfc_pkg::VQ_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	cfc_pkg::verdict_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]   count_q;
	logic              do_wr, do_rd;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd) count_q <= count_q + CNTW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CNTW'(1);
		end
	end

endmodule

// File: hdl/cfc_emitter.sv
// back end: turns each verdict into an error or confirm response frame
module cfc_emitter (
	input  logic              clk,
	input  logic              arst_n,
	input  cfc_pkg::cfg_t     cfg,
	input  cfc_pkg::verdict_t vq_data,
	input  logic              vq_empty,
	output logic              vq_pop,
	output cfc_pkg::tx_t      tx,
	output logic              empty,
	input  logic              pop
);

	logic       busy_q;
	logic [2:0] idx_q;
	logic       ok_q;
	logic [7:0] cmd_q;
	logic       last, take, done, load, cmd_in_range;

	assign last         = ok_q ? (idx_q == cfc_pkg::BYTE_SUM) : (idx_q == cfc_pkg::BYTE_CMD);
	assign take         = pop && busy_q;
	assign done         = take && last;
	assign load         = !vq_empty && (!busy_q || done);
	assign vq_pop       = load;
	assign empty        = !busy_q;
	assign cmd_in_range = (cmd_q[7:3] == 5'd0) && (cmd_q[2:0] != 3'd0);

	// frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= cfc_pkg::BYTE_HDR;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= cfc_pkg::BYTE_HDR;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// verdict being answered
	always_ff @(posedge clk) begin
		if (load) begin
			ok_q  <= vq_data.ok;
			cmd_q <= vq_data.cmd;
		end
	end

	// response byte selection
	always_comb begin
		tx.tx_last         = last;
		tx.decoded_command = 3'd0;
		case (idx_q)
			cfc_pkg::BYTE_HDR:  tx.tx_byte = cfc_pkg::FRAME_HEADER;
			cfc_pkg::BYTE_LEN:  tx.tx_byte = ok_q ? cfc_pkg::CONF_LENGTH : cfc_pkg::ERR_LENGTH;
			cfc_pkg::BYTE_FUNC: tx.tx_byte = ok_q ? cfg.conf_func : cfg.err_func;
			cfc_pkg::BYTE_CMD:  tx.tx_byte = ok_q ? cmd_q : cfg.err_func;
			cfc_pkg::BYTE_SUM: begin
				tx.tx_byte = cfg.conf_func + cmd_q;
				tx.decoded_command = cmd_in_range ? cmd_q[2:0] : 3'd0;
			end
			default:            tx.tx_byte = 8'd0;
		endcase
	end

endmodule

// File: hdl/command_frame_checker.sv
// command frame checker: one verdict per received packet, answered with a response frame
// Throughput: one received byte per cycle; the parser takes every byte while the queue has room.
// Response: a verdict is queued at the edge that takes a packet's last byte; a free emitter
//   loads it into its own registers, then shows the first byte; a response takes 4 or 5 pops.
// full rises while four verdicts wait in the queue behind the emitter.
// Reset: no packet in progress, queue and emitter empty, function codes 1, 2 and 3.
module command_frame_checker #(
	parameter int MAX_PACKET = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  cfc_pkg::rx_t  rx,
	output logic          empty,
	input  logic          pop,
	output cfc_pkg::tx_t  tx,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);

	cfc_pkg::cfg_t       cfg_q;
	cfc_pkg::verdict_t   verdict, vq_data;
	logic                vq_push, vq_pop, vq_full, vq_empty;
	logic                verdict_valid;

	assign cfg_ready = 1'b1;
	assign full      = vq_full;
	assign vq_push   = verdict_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_func  <= 8'd1;
			cfg_q.err_func  <= 8'd2;
			cfg_q.conf_func <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cfc_pkg::CFG_SET_FUNC:  cfg_q.set_func  <= cfg_data;
				cfc_pkg::CFG_ERR_FUNC:  cfg_q.err_func  <= cfg_data;
				cfc_pkg::CFG_CONF_FUNC: cfg_q.conf_func <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end
	cfc_parser #(
		.MAX_PACKET(MAX_PACKET)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (push && !vq_full),
		.rx           (rx),
		.set_func     (cfg_q.set_func),
		.verdict_valid(verdict_valid),
		.verdict      (verdict)
	);

	// verdict queue
	cfc_vqueue u_vqueue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (vq_push),
		.wr_data(verdict),
		.rd_en  (vq_pop),
		.rd_data(vq_data),
		.full   (vq_full),
		.empty  (vq_empty)
	);

	// back end
	cfc_emitter u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.vq_data (vq_data),
		.vq_empty(vq_empty),
		.vq_pop  (vq_pop),
		.tx      (tx),
		.empty   (empty),
		.pop     (pop)
	);

	// a verdict is never offered to a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		vq_push |-> !vq_full)
		else $error("verdict pushed into full queue");

	// the command code shows only on the last byte of a frame
	a_cmd_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !tx.tx_last) |-> (tx.decoded_command == 3'd0))
		else $error("decoded command outside last byte");

	// finishing a frame with nothing queued leaves the output empty
	a_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && tx.tx_last && vq_empty) |=> empty)
		else $error("output not empty after final byte");

	// a waiting verdict is taken as soon as the emitter is free
	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !vq_empty) |=> !empty)
		else $error("emitter idle with verdict waiting");

endmodule

// File: verif/cfc_response_checker.sv
// response checker for the command frame checker: predicts response frames and compares them
`timescale 1ns / 1ps

module cfc_response_checker #(
	parameter int MAX_PACKET = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          full,
	input  cfc_pkg::rx_t  rx,
	input  logic          empty,
	input  logic          pop,
	input  cfc_pkg::tx_t  tx,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output int            errors,
	output int            pending,
	output int            confirms,
	output int            rejects
);

	// decoded command code for none, and the command codes at the ends of the legal range
	localparam logic [2:0] NO_COMMAND = 3'd0;
	localparam logic [7:0] CMD_AUTO   = 8'd1;
	localparam logic [7:0] CMD_STOP   = 8'd7;
	// byte position counter saturates here
	localparam int COUNT_MAX = 511;

	// function codes as last written
	logic [7:0] set_code;
	logic [7:0] err_code;
	logic [7:0] conf_code;

	// parser shadow state
	logic       in_packet;
	int         byte_pos;
	logic [7:0] frame_len;
	logic [7:0] data_sum;
	logic [7:0] func_byte;
	logic [7:0] cmd_byte;
	logic       hdr_ok;
	logic       sum_seen;
	logic       sum_match;

	cfc_pkg::tx_t resp_q[$];
	int         fail_cnt    = 0;
	int         confirm_cnt = 0;
	int         reject_cnt  = 0;
	int         resp_q_n    = 0;

	assign errors   = fail_cnt;
	assign pending  = resp_q_n;
	assign confirms = confirm_cnt;
	assign rejects  = reject_cnt;

	task automatic report_mismatch(input string msg);
		fail_cnt++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic clear_parse();
		byte_pos  = 0;
		frame_len = '0;
		data_sum  = '0;
		func_byte = '0;
		cmd_byte  = '0;
		hdr_ok    = 1'b0;
		sum_seen  = 1'b0;
		sum_match = 1'b0;
	endtask

	task automatic queue_resp_byte(input logic [7:0] b, input logic last, input logic [2:0] code);
		resp_q.push_back('{tx_byte: b, tx_last: last, decoded_command: code});
	endtask

	// advance the parser by one received byte and queue any response frame
	task automatic parse_rx_byte(input cfc_pkg::rx_t item);
		logic good;
		logic [7:0] cmd;
		if (item.packet_start) begin
			clear_parse();
			in_packet = 1'b1;
		end
		if (!in_packet)
			return;

		if (byte_pos == 0) begin
			hdr_ok = (item.rx_byte == cfc_pkg::FRAME_HEADER);
		end else if (byte_pos == 1) begin
			frame_len = item.rx_byte;
		end else if (byte_pos - 2 < int'(frame_len)) begin
			data_sum = data_sum + item.rx_byte;
			if (byte_pos == 2)
				func_byte = item.rx_byte;
			if (byte_pos == 3)
				cmd_byte = item.rx_byte;
		end else if (byte_pos == 2 + int'(frame_len)) begin
			sum_seen  = 1'b1;
			sum_match = (item.rx_byte == data_sum);
		end
		if (byte_pos < COUNT_MAX)
			byte_pos++;

		if (!item.packet_end)
			return;

		// packet closed: decide between confirm and error frame
		in_packet = 1'b0;
		good = hdr_ok && sum_seen && sum_match && frame_len >= 8'd2 &&
			func_byte == set_code && byte_pos <= MAX_PACKET;
		cmd = cmd_byte;
		clear_parse();

		queue_resp_byte(cfc_pkg::FRAME_HEADER, 1'b0, NO_COMMAND);
		if (!good) begin
			queue_resp_byte(cfc_pkg::ERR_LENGTH, 1'b0, NO_COMMAND);
			queue_resp_byte(err_code, 1'b0, NO_COMMAND);
			queue_resp_byte(err_code, 1'b1, NO_COMMAND);
			reject_cnt++;
		end else begin
			queue_resp_byte(cfc_pkg::CONF_LENGTH, 1'b0, NO_COMMAND);
			queue_resp_byte(conf_code, 1'b0, NO_COMMAND);
			queue_resp_byte(cmd, 1'b0, NO_COMMAND);
			queue_resp_byte(conf_code + cmd, 1'b1,
				(cmd >= CMD_AUTO && cmd <= CMD_STOP) ? cmd[2:0] : NO_COMMAND);
			confirm_cnt++;
		end
	endtask

	// compare one popped response byte with the oldest prediction
	task automatic check_resp_byte(input cfc_pkg::tx_t got);
		cfc_pkg::tx_t want;
		if (resp_q.size() == 0) begin
			report_mismatch($sformatf("response byte 0x%02h with nothing expected", got.tx_byte));
			return;
		end
		want = resp_q.pop_front();
		if (got.tx_byte !== want.tx_byte)
			report_mismatch($sformatf("tx_byte got 0x%02h expected 0x%02h",
				got.tx_byte, want.tx_byte));
		if (got.tx_last !== want.tx_last)
			report_mismatch($sformatf("tx_last got %b expected %b",
				got.tx_last, want.tx_last));
		if (got.decoded_command !== want.decoded_command)
			report_mismatch($sformatf("decoded_command got %0d expected %0d",
				got.decoded_command, want.decoded_command));
	endtask

	// watch all three channels on every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// reset function codes
			set_code  = 8'd1;
			err_code  = 8'd2;
			conf_code = 8'd3;
			in_packet = 1'b0;
			clear_parse();
			resp_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cfc_pkg::CFG_SET_FUNC:  set_code  = cfg_data;
					cfc_pkg::CFG_ERR_FUNC:  err_code  = cfg_data;
					cfc_pkg::CFG_CONF_FUNC: conf_code = cfg_data;
					default:       ;
				endcase
			end
			if (pop && !empty)
				check_resp_byte(tx);
			if (push && !full)
				parse_rx_byte(rx);
		end
		resp_q_n <= resp_q.size();
	end

endmodule

// File: verif/command_frame_checker_tb.sv
// testbench top of the command frame checker: stimulus, idling and verdict
`timescale 1ns / 1ps

module command_frame_checker_tb;

	localparam int         MAX_PACKET    = 24;
	localparam int         STALL_LIMIT   = 4000;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         DRAIN_CYCLES  = 20;
	localparam int         PHASE_BYTES   = 20;
	localparam logic [1:0] CFG_SPARE     = 2'd3;

	typedef logic [7:0] byte_q_t[$];

	typedef enum {
		PK_GOOD, PK_TRAILING, PK_BAD_HEADER, PK_SHORT_LEN, PK_TRUNCATED,
		PK_BAD_SUM, PK_WRONG_FUNC, PK_OVERSIZE, PK_RESTART, PK_NOISE
	} pkt_kind_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         push;
	logic         full;
	cfc_pkg::rx_t rx;
	logic         empty;
	logic         pop;
	cfc_pkg::tx_t tx;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [7:0]   cfg_data;

	int         n_fail;
	int         n_pending;
	int         n_confirm;
	int         n_reject;
	int         n_bytes     = 0;
	int         n_packets   = 0;
	int         n_settings  = 1;
	int         idle_cycles = 0;
	bit         no_gaps     = 1'b0;
	bit         hold_req    = 1'b0;
	logic [7:0] cur_set     = 8'd1;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	command_frame_checker #(
		.MAX_PACKET(MAX_PACKET)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx        (rx),
		.empty     (empty),
		.pop       (pop),
		.tx        (tx),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cfc_response_checker #(
		.MAX_PACKET(MAX_PACKET)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx        (rx),
		.empty     (empty),
		.pop       (pop),
		.tx        (tx),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (n_fail),
		.pending   (n_pending),
		.confirms  (n_confirm),
		.rejects   (n_reject)
	);

	// idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offer one byte and wait for the transaction
	task automatic send_rx(input logic [7:0] b, input logic first, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx   <= '{rx_byte: b, packet_start: first, packet_end: last};
		do @(posedge clk); while (full);
	endtask

	task automatic send_bytes(input byte_q_t q, input bit close);
		foreach (q[i])
			send_rx(q[i], i == 0, close && i == q.size() - 1);
		n_bytes += q.size();
		if (close)
			n_packets++;
	endtask

	// stop offering and wait until every response has been taken
	task automatic wait_idle();
		push <= 1'b0;
		do @(posedge clk); while (n_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [7:0] set_v, input logic [7:0] err_v,
		input logic [7:0] conf_v);
		logic [1:0] idx[4];
		logic [7:0] vals[4];
		idx  = '{cfc_pkg::CFG_SET_FUNC, cfc_pkg::CFG_ERR_FUNC, cfc_pkg::CFG_CONF_FUNC,
			CFG_SPARE};
		vals = '{set_v, err_v, conf_v, 8'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cur_set = set_v;
		n_settings++;
	endtask

	function automatic logic [7:0] pick_cmd();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 8'($urandom_range(1, 7));
		if (r == 7)
			return 8'd0;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] flip_some(input logic [7:0] b);
		return b ^ 8'($urandom_range(1, 255));
	endfunction

	// build one packet of the given kind with random content
	task automatic build_frame(input pkt_kind_t kind, output byte_q_t q);
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] d;
		q.delete();
		len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, MAX_PACKET - 3))
			: 8'($urandom_range(2, 6));
		if (kind == PK_SHORT_LEN)
			len = 8'($urandom_range(0, 1));
		if (kind == PK_OVERSIZE)
			len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(MAX_PACKET, 255))
				: 8'($urandom_range(MAX_PACKET - 2, 40));
		q.push_back(kind == PK_BAD_HEADER ? flip_some(cfc_pkg::FRAME_HEADER)
			: cfc_pkg::FRAME_HEADER);
		q.push_back(len);
		sum = '0;
		for (int i = 0; i < int'(len); i++) begin
			if (i == 0)
				d = (kind == PK_WRONG_FUNC) ? flip_some(cur_set) : cur_set;
			else if (i == 1)
				d = pick_cmd();
			else
				d = 8'($urandom);
			q.push_back(d);
			sum += d;
		end
		q.push_back(kind == PK_BAD_SUM ? flip_some(sum) : sum);
		if (kind == PK_TRAILING) begin
			repeat ($urandom_range(1, 3))
				q.push_back(8'($urandom));
		end
		if (kind == PK_TRUNCATED) begin
			while (q.size() > 1 && (q.size() > int'(len) + 2 || $urandom_range(0, 2) != 0))
				void'(q.pop_back());
		end
	endtask

	task automatic run_random_packet();
		byte_q_t q;
		pkt_kind_t kind;
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)      kind = PK_GOOD;
		else if (r < 60) kind = PK_TRAILING;
		else if (r < 65) kind = PK_BAD_HEADER;
		else if (r < 70) kind = PK_SHORT_LEN;
		else if (r < 75) kind = PK_TRUNCATED;
		else if (r < 80) kind = PK_BAD_SUM;
		else if (r < 85) kind = PK_WRONG_FUNC;
		else if (r < 90) kind = PK_OVERSIZE;
		else if (r < 95) kind = PK_RESTART;
		else             kind = PK_NOISE;

		case (kind)
			PK_NOISE: begin
				// stray bytes between packets are dropped by the block
				repeat ($urandom_range(1, 3))
					send_rx(8'($urandom), 1'b0, 1'($urandom));
			end
			PK_RESTART: begin
				// abandoned packet, then a fresh one restarts the parse
				build_frame(PK_GOOD, q);
				q = q[0:$urandom_range(0, q.size() - 2)];
				send_bytes(q, 1'b0);
				build_frame(PK_GOOD, q);
				send_bytes(q, 1'b1);
			end
			default: begin
				build_frame(kind, q);
				send_bytes(q, 1'b1);
			end
		endcase
	endtask

	// response side: random stalls, one long hold-off on request
	initial begin : drain_responses
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// watchdog: ends the run when no transaction happens for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("command_frame_checker_tb NOT OK");
			$finish;
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		byte_q_t q;
		arst_n    = 1'b0;
		push      = 1'b0;
		rx        = '0;
		pop       = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray byte while idle, one-byte packet
		send_rx(8'hFF, 1'b0, 1'b1);
		q = '{8'h00};
		send_bytes(q, 1'b1);
		// restart mid-packet, then shortest valid frame with the top command
		q = '{cfc_pkg::FRAME_HEADER, 8'd2};
		send_bytes(q, 1'b0);
		q = '{cfc_pkg::FRAME_HEADER, 8'd2, 8'd1, 8'd7, 8'd8};
		send_bytes(q, 1'b1);
		// command out of range, with a trailing byte after the checksum
		q = '{cfc_pkg::FRAME_HEADER, 8'd2, 8'd1, 8'd0, 8'd1, 8'hFF};
		send_bytes(q, 1'b1);
		// bad checksum
		q = '{cfc_pkg::FRAME_HEADER, 8'd2, 8'd1, 8'd1, 8'd0};
		send_bytes(q, 1'b1);
		// packet ends before its checksum
		q = '{cfc_pkg::FRAME_HEADER, 8'd5, 8'd1};
		send_bytes(q, 1'b1);

		// random phases over several register settings
		for (int p = 0; p < 5; p++) begin
			int target;
			wait_idle();
			case (p)
				1: write_regs(8'h00, 8'h00, 8'h00);
				2: write_regs(8'hFF, 8'hFF, 8'hFF);
				3, 4: write_regs(8'($urandom), 8'($urandom), 8'($urandom));
				default: ;
			endcase
			no_gaps = (p == 2);
			if (p == 4) begin
				// hold the response side while short packets keep coming
				hold_req = 1'b1;
				no_gaps  = 1'b1;
				repeat (12) begin
					q = '{8'($urandom)};
					send_bytes(q, 1'b1);
				end
				no_gaps = 1'b0;
			end
			target = n_bytes + PHASE_BYTES;
			while (n_bytes < target)
				run_random_packet();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d bytes in %0d packets under %0d register settings",
			n_bytes, n_packets, n_settings);
		$display("responses checked: %0d confirm frames, %0d error frames", n_confirm, n_reject);
		if (n_fail == 0 && n_pending == 0)
			$display("command_frame_checker_tb OK");
		else
			$display("command_frame_checker_tb NOT OK");
		$finish;
	end

endmodule
